/* src/tlsrd_pkg.sv */
// tls record deframer package: per-stream parse context, result word and status codes
// no dependencies; used by tls_record_deframer_core
`default_nettype none

package tlsrd_pkg;

    localparam int unsigned HDR_LEN = 5;
    localparam int unsigned CNT_W   = 3;

    // header count value that marks the payload phase
    localparam logic [CNT_W-1:0] CNT_PAYLOAD  = CNT_W'(HDR_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST_HDR = CNT_W'(HDR_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_LEN_HI   = 3'd3;

    localparam logic [15:0] VER_TLS10 = 16'h0301;
    localparam logic [15:0] VER_TLS11 = 16'h0302;
    localparam logic [15:0] VER_TLS12 = 16'h0303;

    localparam logic [7:0] TYPE_MIN = 8'd20;
    localparam logic [7:0] TYPE_MAX = 8'd23;

    typedef enum logic [1:0] {
        ST_PAYLOAD     = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_BAD_VERSION = 2'd2,
        ST_BAD_TYPE    = 2'd3
    } tlsrd_status_t;

    typedef struct packed {
        logic [CNT_W-1:0] hdr_cnt;
        logic [23:0]      hdr_bytes;  // type in 23:16, version in 15:0
        logic [15:0]      rem_len;
        logic             skip;
        logic             at_first;
    } tlsrd_ctx_t;

    typedef struct packed {
        tlsrd_status_t status;
        logic          last_byte;
        logic          first_byte;
        logic          explicit_iv;
        logic [15:0]   record_version;
        logic [7:0]    record_type;
        logic [7:0]    payload_byte;
        logic          stream_dir;
    } tlsrd_result_t;

    function automatic tlsrd_result_t make_result(
        input logic          dir,
        input logic [7:0]    byte_val,
        input logic [23:0]   hdr,
        input logic          first,
        input logic          last,
        input tlsrd_status_t status
    );
        tlsrd_result_t r;
        r.stream_dir     = dir;
        r.payload_byte   = byte_val;
        r.record_type    = hdr[23:16];
        r.record_version = hdr[15:0];
        r.explicit_iv    = (hdr[15:0] == VER_TLS12);
        r.first_byte     = first;
        r.last_byte      = last;
        r.status         = status;
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/tls_record_deframer_core.sv */
// tls record deframer top level: header gathering, checks and payload tagging
// depends on tlsrd_pkg
`default_nettype none

// Takes one byte a cycle of a TLS byte stream, tagged in s_tuser with its direction,
// and keeps a separate parse context for each direction. Each record's five header
// bytes (type, version, length) are gathered, the version (TLS 1.0 to 1.2) and type
// (20 to 23) are checked, and the payload bytes then leave one per word with the
// header fields, an explicit-IV flag and first/last marks. A bad header gives one
// error word and its payload is swallowed; a zero-length record with a good header gives
// one empty-record word. Header bytes and swallowed bytes give no output word. A byte
// passes through an input register and a result register, and one byte is taken every
// cycle while the output side keeps up; the per-direction context is read and written
// between the two registers. Bytes of a direction at or above NUM_STREAMS are dropped.
module tls_record_deframer_core #(
    parameter int unsigned NUM_STREAMS = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] direction
    // result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // [7:0] payload_byte, [15:8] record_type, [31:16] record_version,
    // [32] explicit_iv, [33] first_byte, [39:34] zero
    output      logic [39:0] m_tdata,
    output      logic        m_tlast,   // last_byte
    output      logic [2:0]  m_tuser    // [0] stream_dir, [2:1] status
);
    import tlsrd_pkg::*;

    localparam int unsigned IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

    tlsrd_ctx_t    ctx_reg  [NUM_STREAMS];
    tlsrd_ctx_t    ctx_next [NUM_STREAMS];

    logic          in_valid_reg;
    logic          in_dir_reg;
    logic [7:0]    in_byte_reg;

    logic          m_valid_reg;
    tlsrd_result_t m_res_reg;

    logic          out_free;
    logic          consume;
    logic          s_hs;
    logic          in_ok;
    logic [IDX_W-1:0] idx;

    tlsrd_ctx_t    cur;
    tlsrd_ctx_t    upd;
    tlsrd_result_t res;
    logic          res_vld;
    tlsrd_status_t hdr_status;
    logic          hdr_bad;
    logic          len_zero;
    logic          pay_last;

    assign out_free = !m_valid_reg || m_tready;
    assign consume  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_hs     = s_tvalid && s_tready;

    assign in_ok = (32'(in_dir_reg) < NUM_STREAMS);
    assign idx   = IDX_W'(in_dir_reg);

    always_comb begin
        for (int i = 0; i < NUM_STREAMS; i++) begin
            ctx_next[i] = ctx_reg[i];
        end
        cur        = ctx_reg[idx];
        upd        = cur;
        res        = '0;
        res_vld    = 1'b0;
        hdr_status = ST_PAYLOAD;
        hdr_bad    = 1'b0;
        len_zero   = 1'b0;
        pay_last   = (cur.rem_len <= 16'd1);

        if (cur.hdr_cnt != CNT_PAYLOAD) begin
            // header phase: type and version bytes, then length high and low
            if (cur.hdr_cnt < CNT_LEN_HI) begin
                upd.hdr_bytes = {cur.hdr_bytes[15:0], in_byte_reg};
            end else begin
                upd.rem_len = {cur.rem_len[7:0], in_byte_reg};
            end
            len_zero = (upd.rem_len == 16'd0);

            // version is checked before type
            if (cur.hdr_bytes[15:0] != VER_TLS10 && cur.hdr_bytes[15:0] != VER_TLS11 &&
                cur.hdr_bytes[15:0] != VER_TLS12) begin
                hdr_status = ST_BAD_VERSION;
            end else if (cur.hdr_bytes[23:16] < TYPE_MIN ||
                         cur.hdr_bytes[23:16] > TYPE_MAX) begin
                hdr_status = ST_BAD_TYPE;
            end
            hdr_bad = (hdr_status != ST_PAYLOAD);

            if (cur.hdr_cnt != CNT_LAST_HDR) begin
                upd.hdr_cnt = cur.hdr_cnt + 3'd1;
            end else begin
                upd.at_first = 1'b1;
                upd.skip     = hdr_bad && !len_zero;
                upd.hdr_cnt  = len_zero ? '0 : CNT_PAYLOAD;
                if (hdr_bad) begin
                    res     = make_result(in_dir_reg, 8'd0, cur.hdr_bytes, 1'b1, 1'b1,
                                          hdr_status);
                    res_vld = 1'b1;
                end else if (len_zero) begin
                    res     = make_result(in_dir_reg, 8'd0, cur.hdr_bytes, 1'b1, 1'b1,
                                          ST_EMPTY);
                    res_vld = 1'b1;
                end
            end
        end else begin
            if (!cur.skip) begin
                res     = make_result(in_dir_reg, in_byte_reg, cur.hdr_bytes, cur.at_first,
                                      pay_last, ST_PAYLOAD);
                res_vld = 1'b1;
            end
            if (pay_last) begin
                upd.rem_len  = '0;
                upd.hdr_cnt  = '0;
                upd.skip     = 1'b0;
                upd.at_first = 1'b1;
            end else begin
                upd.rem_len  = cur.rem_len - 16'd1;
                upd.at_first = 1'b0;
            end
        end

        if (consume && in_ok) begin
            ctx_next[idx] = upd;
        end else begin
            res_vld = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_STREAMS; i++) begin
                ctx_reg[i] <= '{hdr_cnt: '0, hdr_bytes: '0, rem_len: '0,
                               skip: 1'b0, at_first: 1'b1};
            end
        end else begin
            for (int i = 0; i < NUM_STREAMS; i++) begin
                ctx_reg[i] <= ctx_next[i];
            end
            if (s_hs) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                m_valid_reg <= res_vld;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_hs) begin
            in_dir_reg  <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
        if (consume) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_res_reg.last_byte;
    assign m_tuser  = {m_res_reg.status, m_res_reg.stream_dir};
    assign m_tdata  = {6'd0, m_res_reg.first_byte, m_res_reg.explicit_iv,
                       m_res_reg.record_version, m_res_reg.record_type,
                       m_res_reg.payload_byte};

    // error and empty-record words stand alone in their record
    a_single_word_record: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_res_reg.status != ST_PAYLOAD |->
            m_res_reg.first_byte && m_res_reg.last_byte && m_res_reg.payload_byte == 8'd0)
        else $error("non-payload word not a single-word record");

    // explicit iv flag follows the version it was taken from
    a_iv_matches_version: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_res_reg.explicit_iv == (m_res_reg.record_version == VER_TLS12))
        else $error("explicit iv flag disagrees with version");

    // an empty result slot never holds back the input side
    a_no_stall_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with free result register");

endmodule

`default_nettype wire
